@@ sv/sbit_pkg.sv @@
// shared types and constants of the segment versus box table intersection unit
package sbit_pkg;

    localparam int MAX_BOXES  = 16;
    localparam int COORD_BITS = 20;
    localparam int HALF_BITS  = COORD_BITS - 1;
    localparam int IDX_W      = $clog2(MAX_BOXES);
    localparam int CNT_W      = $clog2(MAX_BOXES + 1);
    // slab distances and deltas need two bits above a coordinate
    localparam int NUM_W      = COORD_BITS + 2;
    localparam int PROD_W     = 2 * NUM_W;

    localparam int IN_DATA_W  = 168;
    localparam int OUT_DATA_W = 8;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic        [HALF_BITS-1:0]  t_half;
    typedef logic signed [NUM_W-1:0]      t_num;
    typedef logic        [NUM_W-1:0]      t_den;
    typedef logic        [PROD_W-1:0]     t_prod;

    typedef struct packed {
        t_half  half_y;
        t_half  half_x;
        t_coord center_y;
        t_coord center_x;
    } t_box;

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_QUERY = 1'b1
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FETCH,
        S_SLAB,
        S_MUL1,
        S_MUL2,
        S_CMP,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        OP_LO,
        OP_HI,
        OP_FIN
    } t_op;

endpackage

@@ sv/segment_box_intersection_test_unit.sv @@
// segment versus box table intersection test, top level
// A table of 16 axis-aligned boxes sits in one synchronous memory with a
// registered read, with valid bits in flip-flops cleared at reset. A write
// transaction (tuser = 0) fills or clears one slot and gives no result. A
// query transaction (tuser = 1) walks the slots, passing over empty ones one
// per cycle, reads each valid box, and runs the Liang-Barsky slab test with
// exact fraction compares on one shared 22x22 multiplier: each compare forms
// two products in turn and then compares them, and a valid box takes a scan
// step, a fetch step, up to four slab steps and up to five compares. A query
// stops at the first hit and returns one result transaction with hit in bit 0.
// Touching a box counts as a hit; a zero-length segment is tested as a point.
// New transactions are taken only while no query is in flight; the output
// register lets a write be taken while a result waits.
module segment_box_intersection_test_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // entry_index, entry_valid, in_center_x, in_center_y, in_half_x,
    // in_half_y, start_x, start_y, end_x, end_y
    input  logic [sbit_pkg::IN_DATA_W-1:0]   s_tdata,
    // cmd
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // hit
    output logic [sbit_pkg::OUT_DATA_W-1:0]  m_tdata
);

    localparam int NW = sbit_pkg::NUM_W;
    localparam int IW = sbit_pkg::IDX_W;

    // input field unpacking
    logic [IW-1:0]         w_index;
    logic                  w_valid;
    sbit_pkg::t_box        w_box;
    sbit_pkg::t_coord      w_sx, w_sy, w_ex, w_ey;

    assign w_index          = s_tdata[IW-1:0];
    assign w_valid          = s_tdata[4];
    assign w_box.center_x   = s_tdata[24:5];
    assign w_box.center_y   = s_tdata[44:25];
    assign w_box.half_x     = s_tdata[63:45];
    assign w_box.half_y     = s_tdata[82:64];
    assign w_sx             = s_tdata[102:83];
    assign w_sy             = s_tdata[122:103];
    assign w_ex             = s_tdata[142:123];
    assign w_ey             = s_tdata[162:143];

    logic w_acc;
    assign w_acc = s_tvalid && s_tready;

    // box memory and valid bits
    sbit_pkg::t_box                  mem [sbit_pkg::MAX_BOXES];
    sbit_pkg::t_box                  r_rd;
    logic [sbit_pkg::MAX_BOXES-1:0]  r_valid;

    sbit_pkg::t_state  r_state, n_state;
    logic [sbit_pkg::CNT_W-1:0] r_idx, n_idx;
    logic [1:0]        r_k, n_k;
    sbit_pkg::t_num    r_sx, r_sy, r_dx, r_dy, n_sx, n_sy, n_dx, n_dy;
    sbit_pkg::t_num    r_q [4];
    sbit_pkg::t_num    n_q [4];
    sbit_pkg::t_num    r_lo_n, r_hi_n, r_an, r_bn, n_lo_n, n_hi_n, n_an, n_bn;
    sbit_pkg::t_den    r_lo_d, r_hi_d, r_ad, r_bd, n_lo_d, n_hi_d, n_ad, n_bd;
    sbit_pkg::t_op     r_op, n_op;
    sbit_pkg::t_prod   r_pa, r_pb, n_pa, n_pb;
    logic              r_out_valid, r_hit;

    logic              w_at_end, w_box_ok;
    sbit_pkg::t_num    w_p, w_qk;
    logic [1:0]        w_rank_a, w_rank_b;
    logic              w_gt, w_lt;
    logic              w_out_free;
    sbit_pkg::t_den    w_ma, w_mb;
    sbit_pkg::t_prod   w_prod;
    sbit_pkg::t_num    w_cxl, w_cxh, w_cyl, w_cyh;

    assign w_at_end   = (r_idx == sbit_pkg::CNT_W'(sbit_pkg::MAX_BOXES));
    assign w_box_ok   = r_valid[r_idx[IW-1:0]];
    assign w_out_free = !r_out_valid || m_tready;

    // slab k: p is -dx, dx, -dy, dy
    always_comb begin
        case (r_k)
            2'd0:    w_p = -r_dx;
            2'd1:    w_p = r_dx;
            2'd2:    w_p = -r_dy;
            default: w_p = r_dy;
        endcase
        w_qk = r_q[r_k];
    end

    // box bounds from the memory read
    assign w_cxl = NW'(r_rd.center_x) - NW'({1'b0, r_rd.half_x});
    assign w_cxh = NW'(r_rd.center_x) + NW'({1'b0, r_rd.half_x});
    assign w_cyl = NW'(r_rd.center_y) - NW'({1'b0, r_rd.half_y});
    assign w_cyh = NW'(r_rd.center_y) + NW'({1'b0, r_rd.half_y});

    // shared multiplier: |an|*bd in S_MUL1, |bn|*ad in S_MUL2
    always_comb begin
        if (r_state == sbit_pkg::S_MUL1) begin
            w_ma = r_an[NW-1] ? sbit_pkg::t_den'(-r_an) : sbit_pkg::t_den'(r_an);
            w_mb = r_bd;
        end else begin
            w_ma = r_bn[NW-1] ? sbit_pkg::t_den'(-r_bn) : sbit_pkg::t_den'(r_bn);
            w_mb = r_ad;
        end
        w_prod = w_ma * w_mb;
    end

    // sign of an/ad - bn/bd; rank orders negative, zero, positive
    always_comb begin
        w_rank_a = r_an[NW-1] ? 2'd0 : ((r_an == '0) ? 2'd1 : 2'd2);
        w_rank_b = r_bn[NW-1] ? 2'd0 : ((r_bn == '0) ? 2'd1 : 2'd2);
        if (w_rank_a != w_rank_b) begin
            w_gt = w_rank_a > w_rank_b;
            w_lt = w_rank_a < w_rank_b;
        end else if (w_rank_a == 2'd1) begin
            w_gt = 1'b0;
            w_lt = 1'b0;
        end else if (w_rank_a == 2'd2) begin
            w_gt = r_pa > r_pb;
            w_lt = r_pa < r_pb;
        end else begin
            w_gt = r_pa < r_pb;
            w_lt = r_pa > r_pb;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sbit_pkg::S_IDLE: begin
                if (w_acc && s_tuser == sbit_pkg::CMD_QUERY) n_state = sbit_pkg::S_SCAN;
            end
            sbit_pkg::S_SCAN: begin
                if (w_at_end) n_state = sbit_pkg::S_DONE;
                else if (w_box_ok) n_state = sbit_pkg::S_FETCH;
            end
            sbit_pkg::S_FETCH: n_state = sbit_pkg::S_SLAB;
            sbit_pkg::S_SLAB: begin
                if (w_p == '0) begin
                    if (w_qk[NW-1]) n_state = sbit_pkg::S_SCAN;
                    else if (r_k == 2'd3) n_state = sbit_pkg::S_MUL1;
                end else begin
                    n_state = sbit_pkg::S_MUL1;
                end
            end
            sbit_pkg::S_MUL1: n_state = sbit_pkg::S_MUL2;
            sbit_pkg::S_MUL2: n_state = sbit_pkg::S_CMP;
            sbit_pkg::S_CMP: begin
                if (r_op == sbit_pkg::OP_FIN) begin
                    n_state = w_gt ? sbit_pkg::S_SCAN : sbit_pkg::S_DONE;
                end else begin
                    n_state = (r_k == 2'd3) ? sbit_pkg::S_MUL1 : sbit_pkg::S_SLAB;
                end
            end
            sbit_pkg::S_DONE: begin
                if (w_out_free) n_state = sbit_pkg::S_IDLE;
            end
            default: n_state = sbit_pkg::S_IDLE;
        endcase
    end

    // datapath next values
    always_comb begin
        n_idx  = r_idx;
        n_k    = r_k;
        n_sx   = r_sx;
        n_sy   = r_sy;
        n_dx   = r_dx;
        n_dy   = r_dy;
        n_q    = r_q;
        n_lo_n = r_lo_n;
        n_lo_d = r_lo_d;
        n_hi_n = r_hi_n;
        n_hi_d = r_hi_d;
        n_an   = r_an;
        n_ad   = r_ad;
        n_bn   = r_bn;
        n_bd   = r_bd;
        n_op   = r_op;
        n_pa   = r_pa;
        n_pb   = r_pb;
        case (r_state)
            sbit_pkg::S_IDLE: begin
                n_idx = '0;
                n_sx  = NW'(w_sx);
                n_sy  = NW'(w_sy);
                n_dx  = NW'(w_ex) - NW'(w_sx);
                n_dy  = NW'(w_ey) - NW'(w_sy);
            end
            sbit_pkg::S_SCAN: begin
                if (!w_at_end && !w_box_ok) n_idx = r_idx + 1'b1;
            end
            sbit_pkg::S_FETCH: begin
                n_q[0] = r_sx - w_cxl;
                n_q[1] = w_cxh - r_sx;
                n_q[2] = r_sy - w_cyl;
                n_q[3] = w_cyh - r_sy;
                n_k    = 2'd0;
                n_lo_n = '0;
                n_lo_d = NW'(1);
                n_hi_n = NW'(1);
                n_hi_d = NW'(1);
            end
            sbit_pkg::S_SLAB: begin
                if (w_p == '0) begin
                    if (w_qk[NW-1]) begin
                        n_idx = r_idx + 1'b1;
                    end else if (r_k == 2'd3) begin
                        n_an = r_lo_n;
                        n_ad = r_lo_d;
                        n_bn = r_hi_n;
                        n_bd = r_hi_d;
                        n_op = sbit_pkg::OP_FIN;
                    end else begin
                        n_k = r_k + 1'b1;
                    end
                end else if (w_p[NW-1]) begin
                    n_an = -w_qk;
                    n_ad = sbit_pkg::t_den'(-w_p);
                    n_bn = r_lo_n;
                    n_bd = r_lo_d;
                    n_op = sbit_pkg::OP_LO;
                end else begin
                    n_an = w_qk;
                    n_ad = sbit_pkg::t_den'(w_p);
                    n_bn = r_hi_n;
                    n_bd = r_hi_d;
                    n_op = sbit_pkg::OP_HI;
                end
            end
            sbit_pkg::S_MUL1: n_pa = w_prod;
            sbit_pkg::S_MUL2: n_pb = w_prod;
            sbit_pkg::S_CMP: begin
                if (r_op == sbit_pkg::OP_FIN) begin
                    if (w_gt) n_idx = r_idx + 1'b1;
                end else begin
                    if (r_op == sbit_pkg::OP_LO && w_gt) begin
                        n_lo_n = r_an;
                        n_lo_d = r_ad;
                    end
                    if (r_op == sbit_pkg::OP_HI && w_lt) begin
                        n_hi_n = r_an;
                        n_hi_d = r_ad;
                    end
                    if (r_k == 2'd3) begin
                        n_an = n_lo_n;
                        n_ad = n_lo_d;
                        n_bn = n_hi_n;
                        n_bd = n_hi_d;
                        n_op = sbit_pkg::OP_FIN;
                    end else begin
                        n_k = r_k + 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    // box memory: write port from a write transaction, registered read
    always_ff @(posedge i_clk) begin
        if (w_acc && s_tuser == sbit_pkg::CMD_WRITE) mem[w_index] <= w_box;
        r_rd <= mem[r_idx[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sbit_pkg::S_IDLE;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
            r_hit       <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_acc && s_tuser == sbit_pkg::CMD_WRITE) r_valid[w_index] <= w_valid;
            if (r_state == sbit_pkg::S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
                r_hit       <= !w_at_end;
            end else if (m_tvalid && m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_k    <= n_k;
        r_sx   <= n_sx;
        r_sy   <= n_sy;
        r_dx   <= n_dx;
        r_dy   <= n_dy;
        r_q    <= n_q;
        r_lo_n <= n_lo_n;
        r_lo_d <= n_lo_d;
        r_hi_n <= n_hi_n;
        r_hi_d <= n_hi_d;
        r_an   <= n_an;
        r_ad   <= n_ad;
        r_bn   <= n_bn;
        r_bd   <= n_bd;
        r_op   <= n_op;
        r_pa   <= n_pa;
        r_pb   <= n_pb;
    end

    // handshake outputs
    assign s_tready = (r_state == sbit_pkg::S_IDLE);
    assign m_tvalid = r_out_valid;
    assign m_tdata  = {{(sbit_pkg::OUT_DATA_W-1){1'b0}}, r_hit};

`ifndef SYNTHESIS
    // a query transaction starts the table walk
    a_query_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && s_tuser == sbit_pkg::CMD_QUERY) |=> (r_state == sbit_pkg::S_SCAN))
        else $error("query did not start the walk");

    // denominators of both compared fractions stay positive
    a_den_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sbit_pkg::S_CMP) |-> (r_ad != '0 && r_bd != '0))
        else $error("zero denominator in fraction compare");

    // the walk never runs past the table
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sbit_pkg::S_SCAN) |->
            (r_idx <= sbit_pkg::CNT_W'(sbit_pkg::MAX_BOXES)))
        else $error("walk index out of range");
`endif

endmodule
